/* hdl/lrupr_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, scan token and update command shared by the frame cells and control.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W    = IDX_W;
	localparam int CNT_W     = $clog2(FRAMES + 1);

	localparam int PAGE_FW   = 16;
	localparam int FIDX_FW   = 4;
	localparam int FAULT_FW  = 16;
	localparam int NF_W      = 5;

	localparam logic [NF_W-1:0] NF_RESET = NF_W'(16);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		logic  hit;
		idx_t  hit_idx;
		rank_t hit_rank;
		logic  empty;
		idx_t  empty_idx;
		rank_t best_rank;
		idx_t  best_idx;
		page_t best_page;
	} tok_t;

	localparam tok_t TOK_INIT = '0;

	typedef struct packed {
		logic  en;
		logic  clr;
		idx_t  idx;
		logic  load;
		logic  tgt_valid;
		rank_t rank;
		page_t page;
	} upd_t;

	typedef struct packed {
		logic                hit;
		logic [FIDX_FW-1:0]  frame_index;
		logic                evicted_valid;
		logic [PAGE_FW-1:0]  evicted_page;
		logic [FAULT_FW-1:0] fault_count;
	} res_t;

endpackage

/* hdl/lrupr_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the active frame count with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface lrupr_cfg_if import lrupr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [NF_W-1:0] num_frames;

	modport source (output valid, output num_frames, input ready);
	modport sink (input valid, input num_frames, output ready);
endinterface

/* hdl/lrupr_req_if.sv */
// ----------------------------------------------------------------------------
// Reference request channel
// Carries one page reference per valid/ready transfer.
// ----------------------------------------------------------------------------
interface lrupr_req_if import lrupr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PAGE_FW-1:0] page_number;
	logic               end_of_string;

	modport source (output valid, output page_number, output end_of_string, input ready);
	modport sink (input valid, input page_number, input end_of_string, output ready);
endinterface

/* hdl/lrupr_res_if.sv */
// ----------------------------------------------------------------------------
// Replacement result channel
// Carries one lookup result per valid/ready transfer.
// ----------------------------------------------------------------------------
interface lrupr_res_if import lrupr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [FIDX_FW-1:0]  frame_index;
	logic                evicted_valid;
	logic [PAGE_FW-1:0]  evicted_page;
	logic [FAULT_FW-1:0] fault_count;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface

/* hdl/lru_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative LRU frame table built as a row of frame cells.
//
// Channels: req takes one page reference (page_number, end_of_string) per
// transfer; res returns one result (hit, frame_index, evicted_valid,
// evicted_page, fault_count) per reference; cfg writes num_frames, the count
// of active frames, and is always ready.
// Sequence: req is ready only while idle, so one reference is in flight at a
// time; the scan token steps through one frame cell per cycle, then the
// control decides and loads the output register (waiting while an untaken
// result still holds it) before req is ready again.
// Reset: all frames empty, fault count zero, num_frames 16.
// Stall: a held result waits in the output register while the next reference
// is taken and scanned; a second result holds until the first transfers.
// end_of_string empties the table and the fault count after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement_core import lrupr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lrupr_cfg_if.sink   cfg,
	lrupr_req_if.sink   req,
	lrupr_res_if.source res
);

	tok_t  tok_chain [FRAMES+1];
	logic  go_chain  [FRAMES+1];
	page_t key;
	cnt_t  n_act;
	upd_t  upd;

	assign tok_chain[0] = TOK_INIT;

	lrupr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req      (req),
		.res      (res),
		.key      (key),
		.n_act    (n_act),
		.go0      (go_chain[0]),
		.go_last  (go_chain[FRAMES]),
		.tok_last (tok_chain[FRAMES]),
		.upd      (upd)
	);

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.n_act   (n_act),
			.key     (key),
			.go_in   (go_chain[i]),
			.tok_in  (tok_chain[i]),
			.upd     (upd),
			.go_out  (go_chain[i+1]),
			.tok_out (tok_chain[i+1])
		);
	end

endmodule

/* hdl/lrupr_cell.sv */
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame, folds it into the passing scan token, applies updates.
// ----------------------------------------------------------------------------
module lrupr_cell import lrupr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  idx_t  idx,
	input  cnt_t  n_act,
	input  page_t key,
	input  logic  go_in,
	input  tok_t  tok_in,
	input  upd_t  upd,
	output logic  go_out,
	output tok_t  tok_out
);

	page_t page_q;
	logic  valid_q;
	rank_t rank_q;
	logic  go_q;
	tok_t  tok_q;
	tok_t  tok_nxt;
	logic  active;
	logic  ages;

	assign active = CNT_W'(idx) < n_act;

	always_comb begin
		tok_nxt = tok_in;
		if (active) begin
			if (!tok_in.hit && valid_q && (page_q == key)) begin
				tok_nxt.hit      = 1'b1;
				tok_nxt.hit_idx  = idx;
				tok_nxt.hit_rank = rank_q;
			end
			if (!tok_in.empty && !valid_q) begin
				tok_nxt.empty     = 1'b1;
				tok_nxt.empty_idx = idx;
			end
			if (rank_q >= tok_in.best_rank) begin
				tok_nxt.best_rank = rank_q;
				tok_nxt.best_idx  = idx;
				tok_nxt.best_page = page_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else begin
			go_q <= go_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign ages = valid_q && (!upd.tgt_valid || (rank_q < upd.rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.clr) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (upd.idx == idx) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (ages) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && !upd.clr && upd.load && (upd.idx == idx)) begin
			page_q <= upd.page;
		end
	end

	assign go_out  = go_q;
	assign tok_out = tok_q;

endmodule

/* hdl/lrupr_ctrl.sv */
// ----------------------------------------------------------------------------
// LRU replacement control
// Takes references, launches the scan, picks the frame, issues the update.
// ----------------------------------------------------------------------------
module lrupr_ctrl import lrupr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lrupr_cfg_if.sink         cfg,
	lrupr_req_if.sink         req,
	lrupr_res_if.source       res,
	output page_t             key,
	output cnt_t              n_act,
	output logic              go0,
	input  logic              go_last,
	input  tok_t              tok_last,
	output upd_t              upd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]          state_q;
	logic [NF_W-1:0]     nf_q;
	page_t               key_q;
	logic                eos_q;
	logic                go0_q;
	logic [FAULT_FW-1:0] fault_q;
	logic [FAULT_FW-1:0] fault_nxt;
	res_t                res_q;
	res_t                out_q;
	logic                out_v_q;
	logic                decide;
	logic                evict;
	idx_t                pick;
	logic                load_out;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		if (nf_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(nf_q) > 32'(FRAMES)) begin
			n_act = CNT_W'(FRAMES);
		end else begin
			n_act = CNT_W'(nf_q);
		end
	end

	assign decide   = (state_q == ST_SCAN) && go_last;
	assign evict    = !tok_last.hit && !tok_last.empty;
	assign load_out = (state_q == ST_HOLD) && (!out_v_q || res.ready);

	always_comb begin
		if (tok_last.hit) begin
			pick = tok_last.hit_idx;
		end else if (tok_last.empty) begin
			pick = tok_last.empty_idx;
		end else begin
			pick = tok_last.best_idx;
		end
		if (tok_last.hit || (fault_q == '1)) begin
			fault_nxt = fault_q;
		end else begin
			fault_nxt = fault_q + FAULT_FW'(1);
		end
	end

	always_comb begin
		upd.en        = decide;
		upd.clr       = eos_q;
		upd.idx       = pick;
		upd.load      = !tok_last.hit;
		upd.tgt_valid = tok_last.hit || evict;
		upd.rank      = tok_last.hit ? tok_last.hit_rank : tok_last.best_rank;
		upd.page      = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nf_q    <= NF_RESET;
			go0_q   <= 1'b0;
			fault_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			go0_q <= 1'b0;
			if (cfg.valid) begin
				nf_q <= cfg.num_frames;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						go0_q   <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (go_last) begin
						fault_q <= eos_q ? '0 : fault_nxt;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q <= req.page_number[PAGE_BITS-1:0];
			eos_q <= req.end_of_string;
		end
		if (decide) begin
			res_q.hit           <= tok_last.hit;
			res_q.frame_index   <= FIDX_FW'(pick);
			res_q.evicted_valid <= evict;
			res_q.evicted_page  <= evict ? PAGE_FW'(tok_last.best_page) : '0;
			res_q.fault_count   <= fault_nxt;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign key = key_q;
	assign go0 = go0_q;

	assign res.valid         = out_v_q;
	assign res.hit           = out_q.hit;
	assign res.frame_index   = out_q.frame_index;
	assign res.evicted_valid = out_q.evicted_valid;
	assign res.evicted_page  = out_q.evicted_page;
	assign res.fault_count   = out_q.fault_count;

endmodule

/* hdl/lrupr_checker.sv */
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module lrupr_checker import lrupr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic                hit,
	input logic [FIDX_FW-1:0]  frame_index,
	input logic                evicted_valid,
	input logic [PAGE_FW-1:0]  evicted_page,
	input logic [FAULT_FW-1:0] fault_count
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(hit) && $stable(frame_index)
			&& $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_count))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("reference taken while scan in progress");

	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !hit |-> fault_count != '0)
		else $error("fault result with zero fault count");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (hit || !evicted_valid) |-> !(hit && evicted_valid) && evicted_page == '0)
		else $error("eviction reported with hit or stray evicted page");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.hit           (res.hit),
	.frame_index   (res.frame_index),
	.evicted_valid (res.evicted_valid),
	.evicted_page  (res.evicted_page),
	.fault_count   (res.fault_count)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement core testbench
// Drives page references and frame-count writes through the valid/ready
// channels and predicts each result with a cycle-free model of the frame
// table: lookup, empty-frame fill, LRU eviction, rank aging, saturating fault
// count and end-of-string clearing. The run covers directed corner cases,
// random strings over small page pools with random idling on both sides, a
// long result hold-off, and a final string at the full frame count.
// ----------------------------------------------------------------------------
module testbench;
	import lrupr_pkg::*;

	class frame_table_tracker;
		page_t               pages [FRAMES];
		logic                held  [FRAMES];
		rank_t               ranks [FRAMES];
		logic [FAULT_FW-1:0] faults;
		logic [NF_W-1:0]     frames_in_use;
		res_t                awaited [$];
		int                  mismatches;

		function new();
			frames_in_use = NF_RESET;
			mismatches = 0;
			empty_table();
		endfunction

		function void empty_table();
			for (int i = 0; i < FRAMES; i++) begin
				pages[i] = '0;
				held[i] = 1'b0;
				ranks[i] = '0;
			end
			faults = '0;
		endfunction

		function int active_frames();
			if (frames_in_use == 0)
				return 1;
			if (frames_in_use > FRAMES)
				return FRAMES;
			return int'(frames_in_use);
		endfunction

		function void make_youngest(int f);
			int r;
			r = held[f] ? int'(ranks[f]) : FRAMES;
			for (int i = 0; i < FRAMES; i++)
				if (i != f && held[i] && ranks[i] < r)
					ranks[i] = ranks[i] + 1'b1;
			ranks[f] = '0;
			held[f] = 1'b1;
		endfunction

		function void note_reference(page_t page, logic last);
			int    n;
			int    f;
			bit    found;
			bit    vacant;
			rank_t best;
			res_t  want;
			n = active_frames();
			f = 0;
			found = 1'b0;
			vacant = 1'b0;
			want = '0;
			for (int i = 0; i < n; i++)
				if (!found && held[i] && pages[i] == page) begin
					f = i;
					found = 1'b1;
				end
			if (!found) begin
				for (int i = 0; i < n; i++)
					if (!vacant && !held[i]) begin
						f = i;
						vacant = 1'b1;
					end
				if (!vacant) begin
					best = '0;
					f = 0;
					for (int i = 0; i < n; i++)
						if (ranks[i] >= best) begin
							best = ranks[i];
							f = i;
						end
					want.evicted_valid = 1'b1;
					want.evicted_page = pages[f];
				end
			end
			make_youngest(f);
			if (!found) begin
				pages[f] = page;
				if (faults != '1)
					faults = faults + 1'b1;
			end
			want.hit = found;
			want.frame_index = FIDX_FW'(f);
			want.fault_count = faults;
			awaited.push_back(want);
			if (last)
				empty_table();
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, actual %0h", $time, got);
				return;
			end
			want = awaited.pop_front();
			if (got.hit !== want.hit)
				report("hit", 32'(want.hit), 32'(got.hit));
			if (got.frame_index !== want.frame_index)
				report("frame_index", 32'(want.frame_index), 32'(got.frame_index));
			if (got.evicted_valid !== want.evicted_valid)
				report("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
			if (got.evicted_page !== want.evicted_page)
				report("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
			if (got.fault_count !== want.fault_count)
				report("fault_count", 32'(want.fault_count), 32'(got.fault_count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lrupr_cfg_if cfg_if ();
	lrupr_req_if req_if ();
	lrupr_res_if res_if ();

	lru_page_replacement_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.res    (res_if)
	);

	frame_table_tracker tracker;
	bit gaps_on;
	int sink_holdoff;
	int random_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic write_frames(input logic [NF_W-1:0] nf);
		cfg_if.valid <= 1'b1;
		cfg_if.num_frames <= nf;
		do @(posedge clk); while (!cfg_if.ready);
		tracker.frames_in_use = nf;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_reference(input logic [PAGE_FW-1:0] page, input logic last);
		while (gaps_on && $urandom_range(99) < 21) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.page_number <= page;
		req_if.end_of_string <= last;
		do @(posedge clk); while (!req_if.ready);
		tracker.note_reference(page, last);
	endtask

	// hold new references until every result has transferred
	task automatic settle();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (tracker.awaited.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_pool_string(input int count);
		page_t              pool [24];
		int                 size;
		logic [PAGE_FW-1:0] page;
		logic               last;
		size = $urandom_range(1, tracker.active_frames() + 4);
		for (int i = 0; i < size; i++)
			pool[i] = PAGE_FW'($urandom);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 12)
				page = PAGE_FW'($urandom);
			else
				page = pool[$urandom_range(size - 1)];
			if (k == count - 1)
				last = 1'($urandom_range(1));
			else
				last = ($urandom_range(99) < 2);
			send_reference(page, last);
			random_sent++;
		end
	endtask

	initial begin
		res_t got;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.hit = res_if.hit;
				got.frame_index = res_if.frame_index;
				got.evicted_valid = res_if.evicted_valid;
				got.evicted_page = res_if.evicted_page;
				got.fault_count = res_if.fault_count;
				tracker.check_result(got);
			end
			if (!arst_n)
				res_if.ready <= 1'b0;
			else if (sink_holdoff > 0) begin
				res_if.ready <= 1'b0;
				sink_holdoff--;
			end else
				res_if.ready <= !(gaps_on && $urandom_range(99) < 21);
		end
	end

	initial begin
		logic [NF_W-1:0]    nf;
		int                 phase;
		tracker = new();
		gaps_on = 1'b1;
		sink_holdoff = 0;
		random_sent = 0;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.num_frames = '0;
		req_if.valid = 1'b0;
		req_if.page_number = '0;
		req_if.end_of_string = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill, hit, evict at four frames with extreme page numbers
		write_frames(5'd4);
		send_reference(16'h0000, 1'b0);
		send_reference(16'hFFFF, 1'b0);
		send_reference(16'h0001, 1'b0);
		send_reference(16'h8000, 1'b0);
		send_reference(16'hFFFF, 1'b0);
		send_reference(16'h7FFF, 1'b0);
		send_reference(16'h0001, 1'b0);
		send_reference(16'h0000, 1'b1);
		settle();

		// zero frames acts as one
		write_frames(5'd0);
		send_reference(16'h00A5, 1'b0);
		send_reference(16'h00A5, 1'b0);
		send_reference(16'h5A00, 1'b1);
		settle();

		// shrink and grow mid-string so one page sits in two frames
		write_frames(5'd2);
		send_reference(16'h1111, 1'b0);
		send_reference(16'h2222, 1'b0);
		settle();
		write_frames(5'd1);
		send_reference(16'h2222, 1'b0);
		settle();
		write_frames(5'd2);
		send_reference(16'h2222, 1'b0);
		send_reference(16'h3333, 1'b1);
		settle();

		// count above the table size clamps to the table size
		write_frames(5'd31);
		send_reference(16'hC3C3, 1'b0);
		send_reference(16'hC3C3, 1'b0);
		send_reference(16'h3C3C, 1'b1);
		settle();

		phase = 0;
		while (random_sent < 1500) begin
			if ($urandom_range(99) < 30)
				case ($urandom_range(4))
					0: nf = 5'd0;
					1: nf = 5'd1;
					2: nf = 5'd16;
					3: nf = 5'd17;
					default: nf = 5'd31;
				endcase
			else
				nf = NF_W'($urandom_range(31));
			write_frames(nf);
			gaps_on = (phase != 5);
			if (phase == 3) begin
				sink_holdoff = 400;
				run_pool_string(60);
			end else
				run_pool_string($urandom_range(10, 60));
			settle();
			phase++;
		end
		gaps_on = 1'b1;

		write_frames(NF_RESET);
		for (int k = 0; k < 20; k++)
			send_reference(PAGE_FW'($urandom_range(0, 24)), 1'b0);
		settle();

		repeat (FRAMES + 8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
			$display("PASS lru_page_replacement_core");
		else
			$display("FAIL lru_page_replacement_core");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL lru_page_replacement_core");
		$finish;
	end

endmodule
